@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every clock edge outside reset.
`define DHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check prop in the cycle after cond holds.
`define DHT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define DHT_ASSERT(label, clk, rst, prop, msg)
`define DHT_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

@@ hw/rtl/dht_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dht_pkg
// Request/response types, operation and status codes, control bundles.
// ---------------------------------------------------------------------------
package dht_pkg;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 40;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;

   // table size follows the slot index width
   localparam int SLOTS    = 1 << SLOT_W;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [1:0]          slot_state_type;

   // operations
   localparam func_type FN_INSERT = 2'd0;
   localparam func_type FN_DELETE = 2'd1;
   localparam func_type FN_SEARCH = 2'd2;

   // response status
   localparam status_type ST_DONE = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   // slot states
   localparam slot_state_type SL_EMPTY    = 2'd0;
   localparam slot_state_type SL_DELETED  = 2'd1;
   localparam slot_state_type SL_OCCUPIED = 2'd2;

   typedef struct packed {
      func_type             func;
      logic [KEY_W-1:0]     key;
      value_type            value_in;
   } req_type;

   typedef struct packed {
      status_type status;
      slot_type   slot_index;
      value_type  value_out;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic clear;
      logic early;
      logic rd_en;
      logic check;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hash_done;
      logic early_fin;
      logic check_fin;
      logic rsp_free;
   } ctl_sts_type;

endpackage

@@ hw/rtl/dht_hash.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dht_hash
// Home slot and probe step from a key, sliced out of the key bits since
// the table size is a power of two.
// ---------------------------------------------------------------------------
module dht_hash import dht_pkg::*; #(
   parameter int KEY_BITS = 40,
   localparam int IW      = $clog2(SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] key,
   output logic [IW-1:0]       home,
   output logic [IW-1:0]       step,
   output logic                done
);

   localparam int XW = KEY_BITS + 2 * IW;

   logic [XW-1:0] key_x;
   logic [IW-1:0] raw_step;
   logic [IW-1:0] home_ff, home_in, step_ff, step_in;
   logic          done_ff;

   // home is the low index field, step the field above it; a zero step becomes one
   assign key_x    = XW'(key);
   assign raw_step = key_x[2*IW-1:IW];
   assign home_in  = start ? key_x[IW-1:0] : home_ff;
   assign step_in  = start ? ((raw_step == '0) ? IW'(1) : raw_step) : step_ff;

   always_ff @(posedge clock) begin
      home_ff <= home_in;
      step_ff <= step_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   assign home = home_ff;
   assign step = step_ff;
   assign done = done_ff;

endmodule

@@ hw/rtl/dht_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// dht_datapath
// Slot memory, request registers, probe walk, occupancy count, response.
// ---------------------------------------------------------------------------
module dht_datapath import dht_pkg::*; #(
   parameter int KEY_BITS   = 40,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int IW   = $clog2(SLOTS);
   localparam int RW   = IW + 1;
   localparam int CNTW = $clog2(SLOTS + 1);
   localparam int EW   = 2 + KEY_BITS + VALUE_BITS;

   logic [EW-1:0] mem [SLOTS];

   func_type              func_ff, func_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [IW-1:0]         probe_ff, probe_in;
   logic [IW-1:0]         pcnt_ff, pcnt_in;
   logic [IW-1:0]         clr_ff, clr_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [EW-1:0]         rd_ff;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]         home, step;
   logic                  hash_done;

   slot_state_type        rd_state;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  key_hit, decided, put, remove, last_probe, full;
   logic                  early_fin, check_fin, rsp_free;
   status_type            chk_status;
   rsp_type               chk_res, early_res;
   logic [RW-1:0]         sum;
   logic [IW-1:0]         probe_next;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;

   dht_hash #(
      .KEY_BITS (KEY_BITS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.load_req),
      .key   (KEY_BITS'(req_data.key)),
      .home  (home),
      .step  (step),
      .done  (hash_done)
   );

   assign rd_state = rd_ff[EW-1 -: 2];
   assign rd_key   = rd_ff[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
   assign rd_val   = rd_ff[VALUE_BITS-1:0];
   assign key_hit  = (rd_state == SL_OCCUPIED) && (rd_key == key_ff);

   // decide on the slot just read
   always_comb begin
      decided    = 1'b0;
      chk_status = ST_FULL;
      put        = 1'b0;
      remove     = 1'b0;
      case (func_ff)
         FN_INSERT: begin
            if (rd_state == SL_OCCUPIED) begin
               if (key_hit) begin
                  decided    = 1'b1;
                  chk_status = ST_MISS;
               end
            end else begin
               decided    = 1'b1;
               chk_status = ST_DONE;
               put        = 1'b1;
            end
         end
         FN_DELETE, FN_SEARCH: begin
            if (rd_state == SL_EMPTY) begin
               decided    = 1'b1;
               chk_status = ST_MISS;
            end else if (key_hit) begin
               decided    = 1'b1;
               chk_status = ST_DONE;
               remove     = (func_ff == FN_DELETE);
            end
         end
         default: begin
         end
      endcase
   end

   assign last_probe = (pcnt_ff == IW'(SLOTS - 1));
   assign check_fin  = decided || last_probe;
   assign full       = (cnt_ff == CNTW'(SLOTS));
   assign early_fin  = ((func_ff == FN_INSERT) && full) ||
                       ((func_ff != FN_INSERT) && (func_ff != FN_DELETE) &&
                        (func_ff != FN_SEARCH));

   always_comb begin
      chk_res.status     = chk_status;
      chk_res.slot_index = (decided && (chk_status == ST_DONE)) ?
                           slot_type'(probe_ff) : '0;
      chk_res.value_out  = (decided && (chk_status == ST_DONE) && (func_ff == FN_SEARCH)) ?
                           value_type'(rd_val) : '0;
      early_res.status     = (func_ff == FN_INSERT) ? ST_FULL : ST_MISS;
      early_res.slot_index = '0;
      early_res.value_out  = '0;
   end

   // step through the probe sequence modulo the table size
   assign sum        = {1'b0, probe_ff} + {1'b0, step};
   assign probe_next = (sum >= RW'(SLOTS)) ? IW'(sum - RW'(SLOTS)) : sum[IW-1:0];

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      probe_in     = probe_ff;
      pcnt_in      = pcnt_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_req) begin
         func_in = req_data.func;
         key_in  = KEY_BITS'(req_data.key);
         val_in  = VALUE_BITS'(req_data.value_in);
      end
      if (cmd.clear) begin
         clr_in = clr_ff + IW'(1);
      end
      if (cmd.early) begin
         probe_in = home;
         pcnt_in  = '0;
         if (early_fin) begin
            res_in = early_res;
         end
      end
      if (cmd.check) begin
         if (check_fin) begin
            res_in = chk_res;
         end else begin
            probe_in = probe_next;
            pcnt_in  = pcnt_ff + IW'(1);
         end
         if (put) begin
            cnt_in = cnt_ff + CNTW'(1);
         end else if (remove && (cnt_ff != '0)) begin
            cnt_in = cnt_ff - CNTW'(1);
         end
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // single write port: clearing sweep, insert or delete
   assign wr_en   = cmd.clear || (cmd.check && (put || remove));
   assign wr_addr = cmd.clear ? clr_ff : probe_ff;
   always_comb begin
      if (cmd.clear) begin
         wr_data = {SL_EMPTY, {(EW - 2){1'b0}}};
      end else if (put) begin
         wr_data = {SL_OCCUPIED, key_ff, val_ff};
      end else begin
         wr_data = {SL_DELETED, rd_key, rd_val};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[probe_ff];
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      probe_ff <= probe_in;
      res_ff   <= res_in;
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
      if (reset) begin
         pcnt_ff      <= '0;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pcnt_ff      <= pcnt_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sts.clear_last = (clr_ff == IW'(SLOTS - 1));
      sts.hash_done  = hash_done;
      sts.early_fin  = early_fin;
      sts.check_fin  = check_fin;
      sts.rsp_free   = rsp_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DHT_ASSERT(a_count_bound, clock, reset, cnt_ff <= CNTW'(SLOTS), "occupied count above table size")
   `DHT_ASSERT(a_rsp_load_free, clock, reset, !cmd.load_rsp || rsp_free, "pending response overwritten")
   `DHT_ASSERT(a_clear_alone, clock, reset, !(cmd.clear && (cmd.check || cmd.load_req)), "clear overlaps request")
   `DHT_ASSERT_NEXT(a_probe_advance, clock, reset, cmd.check && !check_fin, pcnt_ff == $past(pcnt_ff) + IW'(1), "probe count did not advance")

endmodule

@@ hw/rtl/dht_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// dht_ctrl
// Sequencer: clearing sweep, hash wait, probe read/check loop, response.
// ---------------------------------------------------------------------------
module dht_ctrl import dht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_sts_type sts,
   input  logic        req_valid,
   output logic        req_stall,
   output ctl_cmd_type cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.hash_done) begin
               cmd.early = 1'b1;
               state_in  = sts.early_fin ? S_RESULT : S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.check_fin ? S_RESULT : S_PROBE;
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `DHT_ASSERT(a_hash_in_wait, clock, reset, !sts.hash_done || (state_ff == S_HASH), "hash finished outside hash wait")

endmodule

@@ hw/rtl/double_hash_table_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_hash_table_top
// Requests: one at a time; a new request is taken only once the previous one
// has handed its result to the response register. Each probe is a read of
// the slot memory followed by a check of the slot read.
// Reset: synchronous; a clearing sweep empties every slot before the first
// request is taken.
// ---------------------------------------------------------------------------
module double_hash_table_top import dht_pkg::*; #(
   parameter int KEY_BITS   = 40,
   parameter int VALUE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Control and status between the sequencer and the datapath.
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // Sequencer: hold requests off during the clearing sweep, wait for the
   // hash, alternate read and check per probe, then hand the request's
   // result to the response register once it is free.
   dht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Datapath: slot memory, probe walk, occupancy count and the response
   // register. A finished response waits there while the next request
   // is already accepted and hashed.
   dht_datapath #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/double_hash_table_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_hash_table_top_tb
// Self-checking bench for the double-hashing table. A scoreboard keeps its
// own copy of the slot table, predicts status, slot and value for every
// accepted request, and matches each response in order. Stimulus is a
// directed opener followed by rounds of pool-based traffic (fill, drain,
// mixed) and noise, with random idling on both channels.
// ---------------------------------------------------------------------------
module double_hash_table_top_tb;
   import dht_pkg::*;

   localparam int TABLE_SLOTS  = 1 << SLOT_W;
   localparam int POOL_SIZE    = 80;         // more keys than slots, so the table can fill
   localparam int RANDOM_ITEMS = 1250;
   localparam int HOLD_AT      = 200;        // response count that triggers the long hold-off
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 200;        // idle wait after the final drain, before the verdict
   localparam int CYCLE_LIMIT  = 2000000;

   // the package leaves this operation code unnamed; the block treats it as a no-op
   localparam func_type FN_UNUSED = 2'd3;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} stim_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow table plus the queue of predicted responses
   // -------------------------------------------------------------------------
   class hash_table_scoreboard;
      slot_state_type   slot_state[TABLE_SLOTS];
      logic [KEY_W-1:0] slot_key[TABLE_SLOTS];
      value_type        slot_value[TABLE_SLOTS];
      int               occupied;
      rsp_type          expected_rsps[$];
      int               mismatches;
      int               checked;

      function new();
         foreach (slot_state[i]) begin
            slot_state[i] = SL_EMPTY;
            slot_key[i]   = '0;
            slot_value[i] = '0;
         end
         occupied   = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // Walk the probe sequence for one request and update the shadow table.
      function rsp_type probe_table(req_type r);
         rsp_type  res;
         slot_type step;
         slot_type s;
         int       i;
         res  = '{status: ST_FULL, slot_index: '0, value_out: '0};
         step = r.key[2*SLOT_W-1:SLOT_W];
         if (step == 0) begin
            step = 1;
         end
         s = r.key[SLOT_W-1:0];
         case (r.func)
            FN_INSERT: begin
               if (occupied < TABLE_SLOTS) begin
                  for (i = 0; i < TABLE_SLOTS; i++) begin
                     if (slot_state[s] == SL_OCCUPIED) begin
                        if (slot_key[s] == r.key) begin
                           res.status = ST_MISS;
                           break;
                        end
                     end else begin
                        slot_state[s] = SL_OCCUPIED;
                        slot_key[s]   = r.key;
                        slot_value[s] = r.value_in;
                        occupied++;
                        res.status     = ST_DONE;
                        res.slot_index = s;
                        break;
                     end
                     s = s + step;  // wraps modulo the slot count
                  end
               end
            end
            FN_DELETE, FN_SEARCH: begin
               for (i = 0; i < TABLE_SLOTS; i++) begin
                  if (slot_state[s] == SL_EMPTY) begin
                     res.status = ST_MISS;
                     break;
                  end
                  if (slot_state[s] == SL_OCCUPIED && slot_key[s] == r.key) begin
                     res.status     = ST_DONE;
                     res.slot_index = s;
                     if (r.func == FN_DELETE) begin
                        slot_state[s] = SL_DELETED;
                        if (occupied > 0) begin
                           occupied--;
                        end
                     end else begin
                        res.value_out = slot_value[s];
                     end
                     break;
                  end
                  s = s + step;
               end
            end
            default: begin
               res.status = ST_MISS;
            end
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         expected_rsps.push_back(probe_table(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d with nothing outstanding: status=%0d slot=%0d value=%h",
                        checked, got.status, got.slot_index, got.value_out);
            end
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status || got.slot_index !== want.slot_index ||
             got.value_out !== want.value_out) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d mismatch: expected status=%0d slot=%0d value=%h, got status=%0d slot=%0d value=%h",
                        checked, want.status, want.slot_index, want.value_out,
                        got.status, got.slot_index, got.value_out);
            end
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   hash_table_scoreboard table_sb = new();
   int unsigned accepted_reqs = 0;
   int unsigned cycle_count   = 0;
   int          burst_left    = 0;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   double_hash_table_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            table_sb.check_response(rsp_data);
         end
         if (req_valid && !req_stall) begin
            table_sb.note_request(req_data);
            accepted_reqs++;
         end
      end
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[double_hash_table_top] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------
   // Idle length: mostly zero or short, now and then long.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 82) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[KEY_W-1:0];
   endfunction

   // Pool key: random upper bits, step biased toward the interesting cases
   // (zero step, steps that share factors with the slot count, odd steps).
   function automatic logic [KEY_W-1:0] make_key();
      logic [KEY_W-1:0] k;
      k = random_key();
      case ($urandom_range(0, 7))
         0:       k[2*SLOT_W-1:SLOT_W] = '0;
         1:       k[2*SLOT_W-1:SLOT_W] = 6'd32;
         2:       k[2*SLOT_W-1:SLOT_W] = 6'd16;
         3, 4, 5: k[SLOT_W] = 1'b1;
         default: ;
      endcase
      return k;
   endfunction

   function automatic func_type pick_func(stim_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  return (r < 85) ? FN_INSERT : (r < 95) ? FN_SEARCH : FN_DELETE;
         MODE_DRAIN: return (r < 55) ? FN_DELETE : (r < 85) ? FN_SEARCH : FN_INSERT;
         MODE_MIXED: return (r < 34) ? FN_INSERT : (r < 67) ? FN_DELETE : FN_SEARCH;
         default:    return (r < 25) ? FN_INSERT : (r < 50) ? FN_DELETE :
                            (r < 75) ? FN_SEARCH : FN_UNUSED;
      endcase
   endfunction

   // Offer one request at the falling edge, hold it until taken, then idle unless in a back-to-back stretch.
   task automatic send_request(func_type f, logic [KEY_W-1:0] k, value_type v);
      int          gap;
      int unsigned taken_before;
      req_data     = '{func: f, key: k, value_in: v};
      req_valid    = 1'b1;
      taken_before = accepted_reqs;
      do @(negedge clock); while (accepted_reqs == taken_before);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 49) == 0) begin
         burst_left = $urandom_range(20, 60);   // back-to-back stretch
         gap = 0;
      end else begin
         gap = pick_idle();
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding response.
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (table_sb.pending() != 0) @(negedge clock);
   endtask

   task automatic run_directed();
      logic [KEY_W-1:0] k_zero, k_ones, k_coll, k_new0, k_s32a, k_s32b, k_s32c;
      k_zero = '0;
      k_ones = '1;                                 // home 63, step 63
      k_coll = {28'hABCDE12, 6'd0, 6'd0};          // home 0, zero step
      k_new0 = {28'h5A5A5A5, 6'd0, 6'd0};
      k_s32a = {28'h1111111, 6'd32, 6'd2};         // orbit of two slots: 2 and 34
      k_s32b = {28'h2222222, 6'd32, 6'd34};
      k_s32c = {28'h3333333, 6'd32, 6'd2};
      // lookups on an empty table stop at the home slot
      send_request(FN_SEARCH, k_zero, '0);
      send_request(FN_DELETE, k_zero, '0);
      send_request(FN_INSERT, k_zero, '0);
      send_request(FN_INSERT, k_ones, '1);
      // duplicate insert is refused
      send_request(FN_INSERT, k_zero, 32'h0000_1234);
      send_request(FN_SEARCH, k_zero, '1);
      send_request(FN_SEARCH, k_ones, '0);
      // collision on the home slot, zero step probes the next slot
      send_request(FN_INSERT, k_coll, 32'h8000_0001);
      send_request(FN_DELETE, k_zero, '0);
      // search must skip the deleted slot
      send_request(FN_SEARCH, k_zero, '0);
      send_request(FN_SEARCH, k_coll, '0);
      // insert reuses the deleted slot
      send_request(FN_INSERT, k_new0, 32'hCAFE_F00D);
      send_request(FN_DELETE, k_ones, '0);
      // even step: the orbit fills and probes run out
      send_request(FN_INSERT, k_s32a, 32'h0F0F_0F0F);
      send_request(FN_INSERT, k_s32b, 32'hF0F0_F0F0);
      send_request(FN_INSERT, k_s32c, 32'h5555_AAAA);
      send_request(FN_SEARCH, k_s32c, '0);
      send_request(FN_DELETE, k_s32c, '0);
      // unknown operation changes nothing
      send_request(FN_UNUSED, k_ones, '1);
      send_request(FN_UNUSED, k_zero, '0);
      send_request(FN_DELETE, k_coll, '0);
      send_request(FN_SEARCH, k_coll, '0);
      send_request(FN_SEARCH, k_new0, '0);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off so the block backs up
   // -------------------------------------------------------------------------
   initial begin
      int hold;
      bit held_off;
      hold     = 0;
      held_off = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!held_off && table_sb.checked >= HOLD_AT) begin
            rsp_stall = 1'b1;
            hold      = LONG_HOLD - 1;
            held_off  = 1'b1;
         end else if (rsp_stall) begin
            rsp_stall = 1'b0;
            // now and then a long stretch with no stall at all
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(0, 6);
         end else begin
            hold = pick_idle();
            if (hold > 0) begin
               rsp_stall = 1'b1;
               hold--;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender: reset, directed opener, random rounds, drain and verdict
   // -------------------------------------------------------------------------
   initial begin
      int               random_items;
      int               round_idx;
      int               round_len;
      int               n;
      stim_mode_type    mode;
      func_type         f;
      logic [KEY_W-1:0] k;
      value_type        v;

      // hold reset from time zero, release at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (key_pool[i]) begin
         key_pool[i] = make_key();
      end

      run_directed();
      wait_for_drain();

      random_items = 0;
      round_idx    = 0;
      while (random_items < RANDOM_ITEMS) begin
         // pause the sender once mid-run until the block is empty
         if (round_idx == 12) begin
            wait_for_drain();
         end
         // swap a few pool keys so the table sees fresh traffic
         repeat ($urandom_range(2, 10)) key_pool[$urandom_range(0, POOL_SIZE - 1)] = make_key();
         n = $urandom_range(0, 99);
         if (round_idx == 0 || n < 30) begin
            mode = MODE_FILL;
         end else if (n < 50) begin
            mode = MODE_DRAIN;
         end else if (n < 85) begin
            mode = MODE_MIXED;
         end else begin
            mode = MODE_NOISE;
         end
         round_len = (mode == MODE_FILL) ? $urandom_range(60, 120) : $urandom_range(30, 90);
         for (n = 0; n < round_len; n++) begin
            f = pick_func(mode);
            if (mode == MODE_NOISE || $urandom_range(0, 99) < 3) begin
               k = random_key();
            end else begin
               k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            v = $urandom;
            send_request(f, k, v);
            if (f != FN_UNUSED) begin
               random_items++;
            end
         end
         round_idx++;
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
         $display("[double_hash_table_top] OK");
      end else begin
         $display("[double_hash_table_top] ERROR");
      end
      $finish;
   end

endmodule
